/* design/circular_fifo_with_search_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the circular FIFO with search
// Shorthand for the concurrent checks in the top level. Each macro expects
// clk and rst to be visible where it is used.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_FIFO_WITH_SEARCH_MACROS_SVH
`define CIRCULAR_FIFO_WITH_SEARCH_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CFWS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CFWS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/cfws_pkg.sv */
// ----------------------------------------------------------------------------
// cfws_pkg
// Action and status codes, sequencer states and the result record shared by
// the circular FIFO with search.
// ----------------------------------------------------------------------------
package cfws_pkg;

  localparam int WORD_W = 32;

  typedef enum logic [1:0] {
    ACT_PUSH   = 2'd0,
    ACT_POP    = 2'd1,
    ACT_SEARCH = 2'd2,
    ACT_DUMP   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_START,
    S_POPW,
    S_WALK
  } state_t;

  typedef struct packed {
    status_t                    status;
    logic                       found;
    logic signed [WORD_W-1:0]   word;
    logic                       last;
  } res_t;

endpackage

/* design/cfws_if.sv */
// ----------------------------------------------------------------------------
// Channel interfaces
// Request channel (action and value) and result channel (status, found, word,
// last), both with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface cfws_req_if;
  logic                             valid;
  logic                             ready;
  cfws_pkg::action_t                action;
  logic signed [cfws_pkg::WORD_W-1:0] value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

interface cfws_rsp_if;
  logic                             valid;
  logic                             ready;
  cfws_pkg::status_t                status;
  logic                             found;
  logic signed [cfws_pkg::WORD_W-1:0] word;
  logic                             last;

  modport source (output valid, output status, output found, output word, output last,
                  input ready);
  modport sink   (input valid, input status, input found, input word, input last,
                  output ready);
endinterface

/* design/circular_fifo_with_search.sv */
// ----------------------------------------------------------------------------
// circular_fifo_with_search
// Ring-buffer FIFO of signed 32-bit words with DEPTH slots, holding at most
// DEPTH-1 entries. Each request is a push, pop, search or dump. Push, pop and
// search give one result; dump gives one result per entry, oldest first, with
// last set on the newest (one empty-status result when the queue is empty).
// Requests are taken one at a time. Search and dump walk the stored entries
// through the single read port of the entry memory, one entry per cycle; a
// dump moves on only when the output register can take its result. Results
// sit in an output register, so a new request is taken while the last result
// of the previous one still waits for a transfer.
// ----------------------------------------------------------------------------
`include "circular_fifo_with_search_macros.svh"

module circular_fifo_with_search #(
  parameter int DEPTH = 8
) (
  input  logic       clk,
  input  logic       rst,
  cfws_req_if.sink   req,
  cfws_rsp_if.source rsp
);

  localparam int AW = $clog2(DEPTH);

  logic                               can_emit, emit;
  cfws_pkg::res_t                     res;
  logic                               wr_en, rd_en;
  logic [AW-1:0]                      wr_addr, rd_addr;
  logic signed [cfws_pkg::WORD_W-1:0] wr_data, rd_data;

  logic                               out_valid;
  cfws_pkg::res_t                     out_res;

  cfws_seq #(.DEPTH(DEPTH)) u_seq (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .can_emit (can_emit),
    .emit     (emit),
    .res      (res),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data)
  );

  cfws_mem #(.DEPTH(DEPTH)) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // The output register can take a new result when empty or being drained.
  assign can_emit = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_emit) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (can_emit && emit) begin
      out_res <= res;
    end
  end

  assign rsp.valid  = out_valid;
  assign rsp.status = out_res.status;
  assign rsp.found  = out_res.found;
  assign rsp.word   = out_res.word;
  assign rsp.last   = out_res.last;

  `CFWS_ASSERT_NEXT(a_one_at_a_time, req.valid && req.ready, !req.ready, "request while busy")
  `CFWS_ASSERT_SAME(a_found_ok, rsp.valid && rsp.found, rsp.status == cfws_pkg::ST_OK,
                    "found with bad status")
  `CFWS_ASSERT_SAME(a_err_clean, rsp.valid && rsp.status != cfws_pkg::ST_OK,
                    rsp.word == '0 && rsp.last && !rsp.found, "error result not clean")
  `CFWS_ASSERT_SAME(a_mem_ports, wr_en, !rd_en, "memory read and write in one cycle")

endmodule

/* design/cfws_mem.sv */
// ----------------------------------------------------------------------------
// cfws_mem
// Entry storage: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module cfws_mem #(
  parameter int DEPTH = 8
) (
  input  logic                               clk,
  input  logic                               wr_en,
  input  logic [$clog2(DEPTH)-1:0]           wr_addr,
  input  logic signed [cfws_pkg::WORD_W-1:0] wr_data,
  input  logic                               rd_en,
  input  logic [$clog2(DEPTH)-1:0]           rd_addr,
  output logic signed [cfws_pkg::WORD_W-1:0] rd_data
);

  logic signed [cfws_pkg::WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* design/cfws_seq.sv */
// ----------------------------------------------------------------------------
// cfws_seq
// Sequencer: holds the head and tail pointers, drives the memory ports and
// walks the entries for search and dump, one per cycle unless a dump stalls.
// ----------------------------------------------------------------------------
module cfws_seq #(
  parameter int DEPTH = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  cfws_req_if.sink                           req,
  input  logic                               can_emit,
  output logic                               emit,
  output cfws_pkg::res_t                     res,
  output logic                               wr_en,
  output logic [$clog2(DEPTH)-1:0]           wr_addr,
  output logic signed [cfws_pkg::WORD_W-1:0] wr_data,
  output logic                               rd_en,
  output logic [$clog2(DEPTH)-1:0]           rd_addr,
  input  logic signed [cfws_pkg::WORD_W-1:0] rd_data
);

  localparam int AW = $clog2(DEPTH);

  cfws_pkg::state_t                   state, state_next;
  cfws_pkg::action_t                  act, act_next;
  logic signed [cfws_pkg::WORD_W-1:0] val, val_next;
  logic [AW-1:0]                      head, head_next;
  logic [AW-1:0]                      tail, tail_next;
  logic [AW-1:0]                      ptr, ptr_next;

  logic full, empty, hit, at_end;

  function automatic logic [AW-1:0] nxt(input logic [AW-1:0] i);
    return (i == AW'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  assign empty  = (head == tail);
  assign full   = (nxt(tail) == head);
  assign hit    = (rd_data == val);
  assign at_end = (nxt(ptr) == tail);

  always_comb begin
    state_next = state;
    case (state)
      cfws_pkg::S_IDLE: begin
        if (req.valid) state_next = cfws_pkg::S_START;
      end
      cfws_pkg::S_START: begin
        if (act == cfws_pkg::ACT_PUSH || empty) begin
          if (can_emit) state_next = cfws_pkg::S_IDLE;
        end else if (act == cfws_pkg::ACT_POP) begin
          state_next = cfws_pkg::S_POPW;
        end else begin
          state_next = cfws_pkg::S_WALK;
        end
      end
      cfws_pkg::S_POPW: begin
        if (can_emit) state_next = cfws_pkg::S_IDLE;
      end
      cfws_pkg::S_WALK: begin
        if (can_emit && (at_end || (act == cfws_pkg::ACT_SEARCH && hit))) begin
          state_next = cfws_pkg::S_IDLE;
        end
      end
      default: state_next = cfws_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    req.ready  = (state == cfws_pkg::S_IDLE);
    emit       = 1'b0;
    res        = '{status: cfws_pkg::ST_OK, found: 1'b0, word: '0, last: 1'b1};
    wr_en      = 1'b0;
    wr_addr    = tail;
    wr_data    = val;
    rd_en      = 1'b0;
    rd_addr    = head;
    act_next   = act;
    val_next   = val;
    head_next  = head;
    tail_next  = tail;
    ptr_next   = ptr;
    case (state)
      cfws_pkg::S_IDLE: begin
        if (req.valid) begin
          act_next = req.action;
          val_next = req.value;
        end
      end
      cfws_pkg::S_START: begin
        if (act == cfws_pkg::ACT_PUSH) begin
          res.status = full ? cfws_pkg::ST_FULL : cfws_pkg::ST_OK;
          emit       = can_emit;
          wr_en      = can_emit && !full;
          if (can_emit && !full) tail_next = nxt(tail);
        end else if (empty) begin
          res.status = cfws_pkg::ST_EMPTY;
          emit       = can_emit;
        end else begin
          rd_en    = 1'b1;
          ptr_next = head;
        end
      end
      cfws_pkg::S_POPW: begin
        res.word = rd_data;
        emit     = can_emit;
        if (can_emit) head_next = nxt(head);
      end
      cfws_pkg::S_WALK: begin
        if (act == cfws_pkg::ACT_SEARCH) begin
          if (hit || at_end) begin
            res.found = hit;
            emit      = can_emit;
          end else begin
            rd_en    = 1'b1;
            rd_addr  = nxt(ptr);
            ptr_next = nxt(ptr);
          end
        end else begin
          res.word = rd_data;
          res.last = at_end;
          emit     = can_emit;
          if (can_emit && !at_end) begin
            rd_en    = 1'b1;
            rd_addr  = nxt(ptr);
            ptr_next = nxt(ptr);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cfws_pkg::S_IDLE;
      head  <= '0;
      tail  <= '0;
      ptr   <= '0;
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
      ptr   <= ptr_next;
    end
  end

  always_ff @(posedge clk) begin
    act <= act_next;
    val <= val_next;
  end

endmodule
